// ----- hdl/cbsp_pkg.sv -----
// cbsp_pkg: shared types and constants for the circular brush splat painter
// no dependencies; imported by cbsp_sqrt and the top level
`default_nettype none

package cbsp_pkg;

    localparam int D2_W     = 32;   // squared distance width once inside the brush
    localparam int ROOT_W   = 16;   // distance width, same as the radius
    localparam int RAD_W    = 16;
    localparam int COORD_W  = 17;
    localparam int DIV_QB   = 8;    // quotient bits of every divider
    localparam int SUM_W    = 10;   // r + g + b + power

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_RADIUS   = 3'd2;
    localparam logic [2:0] REG_CHANNEL  = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;

    localparam logic [2:0] CH_NONE    = 3'd4;
    localparam logic       MODE_STAMP = 1'b0;
    localparam logic       MODE_GRAD  = 1'b1;

    typedef struct packed {
        logic            ok;     // texel gets painted if the math allows
        logic            mode;
        logic [1:0]      sel;
        logic            szero;  // gradient divisor is zero
        logic [3:0][7:0] ch;     // original bytes, alpha at index 3
    } side_t;

endpackage

`default_nettype wire

// ----- hdl/cbsp_delay.sv -----
// cbsp_delay: enable-gated shift line carrying valid bits and sideband
// depends on nothing
`default_nettype none

module cbsp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

`default_nettype wire

// ----- hdl/cbsp_sqrt.sv -----
// cbsp_sqrt: pipelined integer square root, one result bit per stage
// depends on cbsp_pkg
`default_nettype none

module cbsp_sqrt (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [cbsp_pkg::D2_W-1:0]   rad,
    output logic      [cbsp_pkg::ROOT_W-1:0] root
);
    import cbsp_pkg::*;

    logic [D2_W-1:0] v_reg [ROOT_W];
    logic [D2_W-1:0] r_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam logic [D2_W-1:0] BIT = D2_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [D2_W-1:0] v_in, r_in, v_next, r_next;
        logic [D2_W:0]   trial;

        if (k == 0)
        begin : g_first
            assign v_in = rad;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        always_comb
        begin
            trial = {1'b0, r_in} + {1'b0, BIT};
            if ({1'b0, v_in} >= trial)
            begin
                v_next = v_in - trial[D2_W-1:0];
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= v_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[ROOT_W-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/cbsp_div.sv -----
// cbsp_div: pipelined restoring divider, one quotient bit per stage
// flags a quotient that does not fit; depends on nothing
`default_nettype none

module cbsp_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 10,
    parameter int Q_W   = 8
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo,
    output logic                  ovf
);
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]    rem_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic             ovf_reg [Q_W+1];

    // first stage: overflow test against den * 2^Q_W
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (CW'(num) >= (CW'(den) << Q_W));
        end
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_stage
        localparam int SH = Q_W - 1 - j;
        logic [CW-1:0] sub;
        logic          take;

        assign sub  = CW'(den_reg[j]) << SH;
        assign take = rem_reg[j] >= sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= take ? rem_reg[j] - sub : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_reg[j] | (take ? (Q_W'(1) << SH) : '0);
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quo = q_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

`default_nettype wire

// ----- hdl/circular_brush_splat_painter.sv -----
// circular_brush_splat_painter: top level, distance stages, power and blend stages
// depends on cbsp_pkg, cbsp_delay, cbsp_sqrt, cbsp_div
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_we, cfg_index, cfg_data               | write only
//  in      | in_valid/in_ready, texel_x .. alpha_in    | request in
//  out     | out_valid/out_ready, red_out .. changed   | request out
//
// one texel per cycle while the output is taken; 3 distance stages, 16 square root
// stages, 9 power divider stages, 1 sum stage, 9 blend divider stages, 1 output
// the whole pipeline moves as one: it holds when the output register is full and
// not taken, so in_ready follows out_ready through one gate
// reset clears the valid bits and loads the register reset values; no clearing pass
`default_nettype none

module circular_brush_splat_painter #(
    parameter int MAP_SIZE  = 4096,
    parameter int FRAC_BITS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [11:0] texel_x,
    input  wire logic [11:0] texel_y,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic [7:0]  alpha_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic [7:0]       alpha_out,
    output logic             texel_changed
);
    import cbsp_pkg::*;

    localparam int PXW = 12 + FRAC_BITS;
    // |px - cx| bound
    localparam int DXW = ((PXW > COORD_W - 1) ? PXW : COORD_W - 1) + 1;
    localparam int SW  = DXW + 1;
    localparam int SQW = 2 * DXW;
    localparam int D2W = SQW + 1;

    // configuration registers
    logic signed [COORD_W-1:0] center_x_reg, center_y_reg;
    logic [RAD_W-1:0]          radius_reg;
    logic [2:0]                channel_reg;
    logic                      mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
            channel_reg  <= CH_NONE;
            mode_reg     <= MODE_STAMP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                REG_CHANNEL:  channel_reg  <= cfg_data[2:0];
                REG_MODE:     mode_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // global advance: everything shifts unless the output is full and stalled
    logic adv;
    logic out_valid_reg;
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;

    // stage a: absolute offsets from the center
    logic signed [SW-1:0] px_s, py_s, ddx, ddy;
    logic [DXW-1:0]       a_dx_reg, a_dy_reg;
    side_t                side_in, a_side_reg;
    logic                 a_valid_reg;

    always_comb
    begin
        px_s = signed'(SW'(texel_x)) <<< FRAC_BITS;
        py_s = signed'(SW'(texel_y)) <<< FRAC_BITS;
        ddx  = px_s - SW'(center_x_reg);
        ddy  = py_s - SW'(center_y_reg);
        side_in.ok    = (int'(texel_x) < MAP_SIZE) && (int'(texel_y) < MAP_SIZE)
                        && (channel_reg < CH_NONE);
        side_in.mode  = mode_reg;
        side_in.sel   = channel_reg[1:0];
        side_in.szero = 1'b0;
        side_in.ch    = {alpha_in, blue_in, green_in, red_in};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg   <= ddx[SW-1] ? DXW'(-ddx) : DXW'(ddx);
            a_dy_reg   <= ddy[SW-1] ? DXW'(-ddy) : DXW'(ddy);
            a_side_reg <= side_in;
        end
    end

    // stage b: squares
    logic [SQW-1:0]       b_sqx_reg, b_sqy_reg;
    logic [2*RAD_W-1:0]   b_r2_reg;
    side_t                b_side_reg;
    logic                 b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_sqx_reg  <= a_dx_reg * a_dx_reg;
            b_sqy_reg  <= a_dy_reg * a_dy_reg;
            b_r2_reg   <= radius_reg * radius_reg;
            b_side_reg <= a_side_reg;
        end
    end

    // stage c: distance squared and inside test
    logic [D2W-1:0]  d2_full;
    logic [D2_W-1:0] c_d2_reg;
    side_t           c_side_next;
    side_t           c_side_reg;
    logic            c_valid_reg;

    assign d2_full = D2W'(b_sqx_reg) + D2W'(b_sqy_reg);

    always_comb
    begin
        c_side_next    = b_side_reg;
        c_side_next.ok = b_side_reg.ok && (d2_full <= D2W'(b_r2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_d2_reg   <= d2_full[D2_W-1:0];
            c_side_reg <= c_side_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // square root
    logic [ROOT_W-1:0] root;
    side_t             d_side;
    logic              d_valid;

    cbsp_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (c_d2_reg),
        .root (root)
    );

    cbsp_delay #(.WIDTH($bits(side_t) + 1), .DEPTH(ROOT_W)) u_dly_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   ({c_valid_reg, c_side_reg}),
        .dout  ({d_valid, d_side})
    );

    // power = 255 * (R - d) / R
    logic [RAD_W-1:0]   rd;
    logic [RAD_W+7:0]   p_num;
    logic [DIV_QB-1:0]  p_q;
    logic               p_ovf;
    side_t              p_side;
    logic               p_valid;

    assign rd    = radius_reg - root;
    assign p_num = {rd, 8'd0} - {8'd0, rd};

    cbsp_div #(.NUM_W(RAD_W + 8), .DEN_W(RAD_W), .Q_W(DIV_QB)) u_div_power (
        .clk (clk),
        .en  (adv),
        .num (p_num),
        .den (radius_reg),
        .quo (p_q),
        .ovf (p_ovf)
    );

    cbsp_delay #(.WIDTH($bits(side_t) + 1), .DEPTH(DIV_QB + 1)) u_dly_power (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   ({d_valid, d_side}),
        .dout  ({p_valid, p_side})
    );

    // stage e: divisor and numerators; zero radius gives zero power
    logic [7:0]       pw;
    logic [SUM_W-1:0] s_sum;
    logic [SUM_W-1:0] e_sum_reg;
    logic [15:0]      e_num_reg [5];
    side_t            e_side_next;
    side_t            e_side_reg;
    logic             e_valid_reg;

    assign pw    = (radius_reg == '0) ? 8'd0 : p_q;
    assign s_sum = SUM_W'(p_side.ch[0]) + SUM_W'(p_side.ch[1])
                 + SUM_W'(p_side.ch[2]) + SUM_W'(pw);

    always_comb
    begin
        e_side_next       = p_side;
        e_side_next.szero = (s_sum == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_sum_reg <= s_sum;
            for (int i = 0; i < 4; i++)
            begin
                e_num_reg[i] <= {p_side.ch[i], 8'd0} - {8'd0, p_side.ch[i]};
            end
            e_num_reg[4] <= {pw, 8'd0} - {8'd0, pw};
            e_side_reg   <= e_side_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= p_valid;
        end
    end

    // blend dividers: four channels and the power
    logic [DIV_QB-1:0] lane_q   [5];
    logic              lane_ovf [5];
    side_t             f_side;
    logic              f_valid;

    for (genvar l = 0; l < 5; l++)
    begin : g_lane
        cbsp_div #(.NUM_W(16), .DEN_W(SUM_W), .Q_W(DIV_QB)) u_div (
            .clk (clk),
            .en  (adv),
            .num (e_num_reg[l]),
            .den (e_sum_reg),
            .quo (lane_q[l]),
            .ovf (lane_ovf[l])
        );
    end

    cbsp_delay #(.WIDTH($bits(side_t) + 1), .DEPTH(DIV_QB + 1)) u_dly_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   ({e_valid_reg, e_side_reg}),
        .dout  ({f_valid, f_side})
    );

    // final combine
    logic [3:0][7:0] res;
    logic            chg;
    logic [8:0]      sel_sum;

    always_comb
    begin
        res     = f_side.ch;
        chg     = 1'b0;
        sel_sum = 9'(lane_q[f_side.sel]) + 9'(lane_q[4]);
        if (f_side.ok)
        begin
            if (f_side.mode == MODE_STAMP)
            begin
                res             = '0;
                res[f_side.sel] = 8'hFF;
                chg             = 1'b1;
            end
            else if (!f_side.szero)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res[i] = lane_ovf[i] ? 8'hFF : lane_q[i];
                end
                // saturating the channel first does not change the capped sum
                if (lane_ovf[f_side.sel] || lane_ovf[4] || sel_sum[8])
                begin
                    res[f_side.sel] = 8'hFF;
                end
                else
                begin
                    res[f_side.sel] = sel_sum[7:0];
                end
                chg = 1'b1;
            end
        end
    end

    side_t out_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_out       <= res[0];
            green_out     <= res[1];
            blue_out      <= res[2];
            alpha_out     <= res[3];
            texel_changed <= chg;
            out_side_reg  <= f_side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= f_valid;
        end
    end

`ifndef ASSERT_OFF
    // an untouched texel must leave with its own bytes
    a_unchanged_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !texel_changed |->
            red_out == out_side_reg.ch[0] && green_out == out_side_reg.ch[1]
            && blue_out == out_side_reg.ch[2] && alpha_out == out_side_reg.ch[3])
        else $error("unchanged texel bytes differ from input");

    // a hard stamp sets exactly one byte to full and the rest to zero
    a_stamp_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && texel_changed && out_side_reg.mode == MODE_STAMP |->
            $countones({red_out == 8'hFF, green_out == 8'hFF,
                        blue_out == 8'hFF, alpha_out == 8'hFF}) == 1
            && $countones({red_out == 8'h00, green_out == 8'h00,
                           blue_out == 8'h00, alpha_out == 8'h00}) == 3)
        else $error("hard stamp result malformed");

    // power never exceeds 255 for a nonzero radius
    a_power_fits: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid && p_side.ok && radius_reg != '0 |-> !p_ovf)
        else $error("power quotient overflow");

    // no painted texel unless it passed the inside and channel tests
    a_changed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && texel_changed |-> out_side_reg.ok)
        else $error("texel painted without passing inside test");
`endif

endmodule

`default_nettype wire
